[hw/rtl/clp_pkg.sv]
package clp_pkg;

  localparam int unsigned CharW     = 8;
  localparam int unsigned PosW      = 5;
  localparam logic [PosW-1:0] POS_SAT     = 5'd19;
  localparam logic [PosW-1:0] POS_TAIL    = 5'd18;
  localparam logic [PosW-1:0] POS_LASTFLD = 5'd17;
  localparam logic [PosW-1:0] POS_PRODUCT = 5'd0;
  localparam logic [PosW-1:0] POS_SIZE    = 5'd7;

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;

  typedef struct packed {
    logic       label_ok;
    logic [6:0] factory;
    logic [6:0] boxes_per_carton;
    logic [6:0] items_per_box;
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [9:0] box_number;
  } label_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_CR) || (c == CH_LF) || (c == CH_TAB);
  endfunction

  function automatic logic product_ok(input logic [7:0] c);
    logic r;
    r = ((c >= "0") && (c <= "8")) || ((c >= "A") && (c <= "Z")) ||
        ((c >= "a") && (c <= "x"));
    if ((c == "1") || (c == "O") || (c == "o")) r = 1'b0;
    return r;
  endfunction

  // zero marks an invalid size code
  function automatic logic [6:0] size_decode(input logic [7:0] c);
    logic [6:0] r;
    logic [7:0] k;
    r = 7'd0;
    k = 8'd0;
    if ((c >= "1") && (c <= "9")) begin
      k = c - "0";
      r = 7'(k) * 7'd5;
    end else if ((c >= "A") && (c <= "K")) begin
      k = c - "A";
      r = 7'd50 + 7'(k) * 7'd5;
    end else if ((c >= "L") && (c <= "N")) begin
      k = c - "L";
      r = 7'd1 + 7'(k);
    end else if (c == "P") begin
      r = 7'd4;
    end else if ((c >= "Q") && (c <= "T")) begin
      k = c - "Q";
      r = 7'd6 + 7'(k);
    end else if ((c >= "U") && (c <= "X")) begin
      k = c - "U";
      r = 7'd11 + 7'(k);
    end else if ((c == "Y") || (c == "Z")) begin
      k = c - "Y";
      r = 7'd16 + 7'(k);
    end else if ((c == "a") || (c == "b")) begin
      k = c - "a";
      r = 7'd18 + 7'(k);
    end
    return r;
  endfunction

endpackage

[hw/rtl/clp_if.sv]
interface clp_scan_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface clp_label_if;
  logic       valid;
  logic       ready;
  logic       label_ok;
  logic [6:0] factory;
  logic [6:0] boxes_per_carton;
  logic [6:0] items_per_box;
  logic [6:0] year;
  logic [3:0] month;
  logic [4:0] day;
  logic [9:0] box_number;

  modport source (output valid, output label_ok, output factory, output boxes_per_carton,
                  output items_per_box, output year, output month, output day,
                  output box_number, input ready);
  modport sink   (input valid, input label_ok, input factory, input boxes_per_carton,
                  input items_per_box, input year, input month, input day,
                  input box_number, output ready);
endinterface

[hw/rtl/carton_label_parser_top.sv]
// carton label parser
// scan channel: one label byte per transaction, last_char high on the final
// byte of a scan. bytes are checked by position as they arrive, so one byte
// can be taken every cycle while the skid stage is empty.
// label channel: exactly one transaction per scan, carrying label_ok and the
// decoded fields; every field reads zero when any check failed.
// result: the result of the final byte is registered into the output stage,
// or into the skid stage while the output is held. throughput: one byte per
// cycle while the skid stage is empty; the check logic between the position
// counter and the output register is combinational.
// reset (rst, synchronous): clears the position counter, the check flags,
// the field accumulators and both output stages; scan.ready is high after.
// receiver stall: a second result is held in a skid stage while the first
// waits, and scan.ready falls only while the skid stage is occupied.
module carton_label_parser_top (
  input logic       clk,
  input logic       rst,
  clp_scan_if.sink  scan,
  clp_label_if.source label
);
  import clp_pkg::*;

  logic   take;
  logic   res_valid;
  label_t res;

  logic   out_valid;
  label_t out_data;
  logic   skid_valid;
  label_t skid_data;

  assign scan.ready = !skid_valid;
  assign take       = scan.valid && scan.ready;

  clp_field_check u_check (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .char_code (scan.char_code),
    .last_char (scan.last_char),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || label.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_valid;
        if (res_valid) out_data <= res;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
      skid_data  <= res;
    end
  end

  assign label.valid            = out_valid;
  assign label.label_ok         = out_data.label_ok;
  assign label.factory          = out_data.factory;
  assign label.boxes_per_carton = out_data.boxes_per_carton;
  assign label.items_per_box    = out_data.items_per_box;
  assign label.year             = out_data.year;
  assign label.month            = out_data.month;
  assign label.day              = out_data.day;
  assign label.box_number       = out_data.box_number;

  // skid stage only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds a result with the output stage empty");

  // a passing label always carries in-range fields
  a_ok_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.label_ok) |->
      (out_data.factory != 7'd0) && (out_data.factory <= 7'd74) &&
      (out_data.month != 4'd0) && (out_data.month <= 4'd12) &&
      (out_data.day != 5'd0) && (out_data.items_per_box != 7'd0))
    else $error("passing label with out-of-range field");

  // a failing label reads as all zero
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.label_ok) |->
      (out_data.factory == 7'd0) && (out_data.boxes_per_carton == 7'd0) &&
      (out_data.items_per_box == 7'd0) && (out_data.year == 7'd0) &&
      (out_data.month == 4'd0) && (out_data.day == 5'd0) &&
      (out_data.box_number == 10'd0))
    else $error("failing label with non-zero field");

  // a final byte taken while the output is held must land in the skid stage
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (res_valid && out_valid && !label.ready) |=> skid_valid)
    else $error("result lost behind a stalled output");

endmodule

[hw/rtl/clp_field_check.sv]
module clp_field_check (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  logic [7:0]      char_code,
  input  logic            last_char,
  output logic            res_valid,
  output clp_pkg::label_t res
);
  import clp_pkg::*;

  logic [PosW-1:0] position, position_next;
  logic            failed, failed_next;
  logic            tail_bad, tail_bad_next;
  logic [3:0]      prev_digit, prev_digit_next;
  logic [6:0]      factory_acc, factory_acc_next;
  logic [6:0]      count_acc, count_acc_next;
  logic [6:0]      size_acc, size_acc_next;
  logic [6:0]      year_acc, year_acc_next;
  logic [3:0]      month_acc, month_acc_next;
  logic [4:0]      day_acc, day_acc_next;
  logic [9:0]      box_acc, box_acc_next;

  logic [3:0] d;
  logic [6:0] pair;
  logic       ok;

  assign d    = char_code[3:0];
  assign pair = 7'(prev_digit) * 7'd10 + 7'(d);

  always_comb begin
    position_next    = (position < POS_SAT) ? position + 5'd1 : position;
    failed_next      = failed;
    tail_bad_next    = tail_bad;
    prev_digit_next  = prev_digit;
    factory_acc_next = factory_acc;
    count_acc_next   = count_acc;
    size_acc_next    = size_acc;
    year_acc_next    = year_acc;
    month_acc_next   = month_acc;
    day_acc_next     = day_acc;
    box_acc_next     = box_acc;

    if (position >= POS_TAIL) begin
      if (!is_space(char_code)) tail_bad_next = 1'b1;
    end else if (position == POS_LASTFLD) begin
      if (is_space(char_code)) tail_bad_next = 1'b1;
    end else if (position == POS_PRODUCT) begin
      if (!product_ok(char_code)) failed_next = 1'b1;
    end else if ((position == 5'd3) || (position == 5'd4)) begin
      // free-form positions
    end else if (position == POS_SIZE) begin
      size_acc_next = size_decode(char_code);
      if (size_acc_next == 7'd0) failed_next = 1'b1;
    end else if (!is_digit(char_code)) begin
      failed_next = 1'b1;
    end else begin
      case (position)
        5'd1, 5'd5, 5'd8, 5'd10, 5'd12: prev_digit_next = d;
        5'd2: begin
          factory_acc_next = pair;
          if ((pair == 7'd0) || (pair > 7'd74)) failed_next = 1'b1;
        end
        5'd6: begin
          count_acc_next = pair;
          if (pair == 7'd0) failed_next = 1'b1;
        end
        5'd9:  year_acc_next = pair;
        5'd11: begin
          month_acc_next = pair[3:0];
          if ((pair == 7'd0) || (pair > 7'd12)) failed_next = 1'b1;
        end
        5'd13: begin
          day_acc_next = pair[4:0];
          if ((pair == 7'd0) || (pair > 7'd31)) failed_next = 1'b1;
        end
        5'd14: box_acc_next = 10'(d) * 10'd100;
        5'd15: box_acc_next = box_acc + 10'(d) * 10'd10;
        5'd16: box_acc_next = box_acc + 10'(d);
        default: ;
      endcase
    end
  end

  // position before the increment must reach 17 for a full-length label
  assign ok = !failed_next && !tail_bad_next && (position >= POS_LASTFLD);

  always_comb begin
    res_valid            = take && last_char;
    res.label_ok         = ok;
    res.factory          = ok ? factory_acc_next : 7'd0;
    res.boxes_per_carton = ok ? count_acc_next   : 7'd0;
    res.items_per_box    = ok ? size_acc_next    : 7'd0;
    res.year             = ok ? year_acc_next    : 7'd0;
    res.month            = ok ? month_acc_next   : 4'd0;
    res.day              = ok ? day_acc_next     : 5'd0;
    res.box_number       = ok ? box_acc_next     : 10'd0;
  end

  always_ff @(posedge clk) begin
    if (rst || (take && last_char)) begin
      position    <= '0;
      failed      <= 1'b0;
      tail_bad    <= 1'b0;
      prev_digit  <= '0;
      factory_acc <= '0;
      count_acc   <= '0;
      size_acc    <= '0;
      year_acc    <= '0;
      month_acc   <= '0;
      day_acc     <= '0;
      box_acc     <= '0;
    end else if (take) begin
      position    <= position_next;
      failed      <= failed_next;
      tail_bad    <= tail_bad_next;
      prev_digit  <= prev_digit_next;
      factory_acc <= factory_acc_next;
      count_acc   <= count_acc_next;
      size_acc    <= size_acc_next;
      year_acc    <= year_acc_next;
      month_acc   <= month_acc_next;
      day_acc     <= day_acc_next;
      box_acc     <= box_acc_next;
    end
  end

endmodule
